/* rtl/ldc_pkg.sv */
// ldc_pkg: shared types, constants and fixed-point helpers for the D2Q9 collision kernel.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package ldc_pkg;

  localparam int DW       = 32;
  localparam int FRAC     = 28;
  localparam int NDIR     = 9;
  localparam int RELAX_W  = 30;
  localparam int LID_W    = 29;
  localparam int KIND_W   = 2;
  localparam int CFG_W    = 30;

  // pipeline geometry
  localparam int DIV_BITS  = 2;
  localparam int DIV_STEPS = DW / DIV_BITS;
  localparam int DIV_LAT   = DIV_STEPS + 2;
  localparam int LANE_LAT  = 8;
  localparam int VEL_IDX   = DIV_LAT + 1;
  localparam int DEPTH     = VEL_IDX + LANE_LAT + 1;

  // cell kinds; the spare code behaves as fluid
  localparam logic [KIND_W-1:0] KIND_FLUID    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LID      = 2'd1;
  localparam logic [KIND_W-1:0] KIND_OBSTACLE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SPARE    = 2'd3;

  // register indexes
  localparam logic REG_RELAX_RATE   = 1'b0;
  localparam logic REG_LID_VELOCITY = 1'b1;

  localparam logic [RELAX_W-1:0] RELAX_RESET = 30'd510027366;
  localparam logic [LID_W-1:0]   LID_RESET   = 29'd24159191;

  typedef logic signed [DW-1:0] q_t;
  typedef logic signed [35:0]   qw_t;
  typedef logic signed [39:0]   acc_t;

  localparam q_t Q_ONE  = 32'sd268435456;
  localparam q_t W_REST = 32'sd119304647;
  localparam q_t W_AXIS = 32'sd29826162;
  localparam q_t W_DIAG = 32'sd7456540;
  localparam q_t K_4P5  = 32'sd1207959552;
  localparam q_t K_1P5  = 32'sd402653184;
  localparam q_t Q_MAX  = 32'sh7fff_ffff;
  localparam q_t Q_MIN  = 32'sh8000_0000;

  typedef logic [NDIR-1:0][DW-1:0] dist_vec_t;

  typedef struct packed {
    dist_vec_t         dists;
    logic [KIND_W-1:0] kind;
  } cell_t;

  typedef struct packed {
    q_t rho;
    q_t ux;
    q_t uy;
  } flow_t;

  typedef struct packed {
    dist_vec_t post;
    q_t        density;
    q_t        vel_x;
    q_t        vel_y;
  } result_t;

  // saturate to the signed 32-bit range
  function automatic q_t sat32(input acc_t v);
    if (v > 40'sd2147483647)       return Q_MAX;
    else if (v < -40'sd2147483648) return Q_MIN;
    else                           return v[DW-1:0];
  endfunction

  // Q4.28 product, floor shift by 28
  function automatic qw_t mulq(input q_t x, input q_t y);
    logic signed [63:0] p;
    p = x * y;
    return p[63:FRAC];
  endfunction

  function automatic logic signed [1:0] dir_x(input int d);
    case (d)
      1, 5, 7: return 2'sd1;
      2, 6, 8: return -2'sd1;
      default: return 2'sd0;
    endcase
  endfunction

  function automatic logic signed [1:0] dir_y(input int d);
    case (d)
      3, 5, 6: return 2'sd1;
      4, 7, 8: return -2'sd1;
      default: return 2'sd0;
    endcase
  endfunction

  function automatic q_t dir_weight(input int d);
    case (d)
      0:          return W_REST;
      1, 2, 3, 4: return W_AXIS;
      default:    return W_DIAG;
    endcase
  endfunction

endpackage

/* rtl/ldc_if.sv */
// ldc_in_if / ldc_out_if: valid-ready channels for cell items and collision results.
// Depends on ldc_pkg for field widths.
`timescale 1ns / 1ps
interface ldc_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] dist_0, dist_1, dist_2, dist_3, dist_4;
  logic signed [31:0] dist_5, dist_6, dist_7, dist_8;
  logic [ldc_pkg::KIND_W-1:0] cell_kind;
  modport source(output valid, dist_0, dist_1, dist_2, dist_3, dist_4, dist_5, dist_6,
                 dist_7, dist_8, cell_kind, input ready);
  modport sink(input valid, dist_0, dist_1, dist_2, dist_3, dist_4, dist_5, dist_6,
               dist_7, dist_8, cell_kind, output ready);
endinterface

interface ldc_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] post_0, post_1, post_2, post_3, post_4;
  logic signed [31:0] post_5, post_6, post_7, post_8;
  logic signed [31:0] density, vel_x, vel_y;
  modport source(output valid, post_0, post_1, post_2, post_3, post_4, post_5, post_6,
                 post_7, post_8, density, vel_x, vel_y, input ready);
  modport sink(input valid, post_0, post_1, post_2, post_3, post_4, post_5, post_6,
               post_7, post_8, density, vel_x, vel_y, output ready);
endinterface

/* rtl/ldc_moments.sv */
// ldc_moments: registered density and x/y momentum sums of one cell.
// Depends on ldc_pkg.
`timescale 1ns / 1ps
module ldc_moments (
  input  logic               clk,
  input  logic               adv,
  input  ldc_pkg::dist_vec_t dists,
  output ldc_pkg::q_t        rho,
  output ldc_pkg::q_t        mom_x,
  output ldc_pkg::q_t        mom_y
);

  ldc_pkg::q_t  rho_r, mom_x_r, mom_y_r;
  ldc_pkg::acc_t sum_rho, sum_x, sum_y;

  // signed sums over the nine directions
  always_comb begin
    sum_rho = '0;
    sum_x   = '0;
    sum_y   = '0;
    for (int d = 0; d < ldc_pkg::NDIR; d++) begin
      sum_rho = sum_rho + 40'($signed(dists[d]));
      if (ldc_pkg::dir_x(d) == 2'sd1)       sum_x = sum_x + 40'($signed(dists[d]));
      else if (ldc_pkg::dir_x(d) == -2'sd1) sum_x = sum_x - 40'($signed(dists[d]));
      if (ldc_pkg::dir_y(d) == 2'sd1)       sum_y = sum_y + 40'($signed(dists[d]));
      else if (ldc_pkg::dir_y(d) == -2'sd1) sum_y = sum_y - 40'($signed(dists[d]));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rho_r   <= ldc_pkg::sat32(sum_rho);
      mom_x_r <= ldc_pkg::sat32(sum_x);
      mom_y_r <= ldc_pkg::sat32(sum_y);
    end
  end

  assign rho   = rho_r;
  assign mom_x = mom_x_r;
  assign mom_y = mom_y_r;

endmodule

/* rtl/ldc_div.sv */
// ldc_div: pipelined restoring divider, (num * 2^28) / den toward zero, saturated.
// Zero when den is not positive. Depends on ldc_pkg.
`timescale 1ns / 1ps
module ldc_div (
  input  logic        clk,
  input  logic        adv,
  input  ldc_pkg::q_t num,
  input  ldc_pkg::q_t den,
  output ldc_pkg::q_t quot
);

  typedef struct packed {
    logic [32:0] rem;
    logic [31:0] sh;
    logic [31:0] quo;
    logic [30:0] dvs;
    logic        neg;
    logic        pos;
    logic        ovf;
  } div_st_t;

  div_st_t     st_r [ldc_pkg::DIV_STEPS+1];
  ldc_pkg::q_t quot_r;
  div_st_t     prep;
  logic [31:0] mag;

  // DIV_BITS quotient bits per stage
  function automatic div_st_t div_step(input div_st_t s);
    div_st_t     t;
    logic [32:0] rem;
    t = s;
    for (int b = 0; b < ldc_pkg::DIV_BITS; b++) begin
      rem  = {t.rem[31:0], t.sh[31]};
      t.sh = {t.sh[30:0], 1'b0};
      if (rem >= {2'b00, t.dvs}) begin
        t.rem = rem - {2'b00, t.dvs};
        t.quo = {t.quo[30:0], 1'b1};
      end else begin
        t.rem = rem;
        t.quo = {t.quo[30:0], 1'b0};
      end
    end
    return t;
  endfunction

  // magnitude, overflow check (|num| >= 16*den) and first remainder
  always_comb begin
    mag       = num[31] ? (~num + 32'd1) : num;
    prep.rem  = {5'b0, mag[31:4]};
    prep.sh   = {mag[3:0], 28'b0};
    prep.quo  = '0;
    prep.dvs  = den[30:0];
    prep.neg  = num[31];
    prep.pos  = !den[31] && (den != '0);
    prep.ovf  = {4'b0, mag} >= {1'b0, den[30:0], 4'b0};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0] <= prep;
      for (int k = 1; k <= ldc_pkg::DIV_STEPS; k++) st_r[k] <= div_step(st_r[k-1]);
    end
  end

  // sign and saturation
  always_ff @(posedge clk) begin
    if (adv) begin
      if (!st_r[ldc_pkg::DIV_STEPS].pos) quot_r <= '0;
      else if (st_r[ldc_pkg::DIV_STEPS].ovf)
        quot_r <= st_r[ldc_pkg::DIV_STEPS].neg ? ldc_pkg::Q_MIN : ldc_pkg::Q_MAX;
      else if (st_r[ldc_pkg::DIV_STEPS].neg)
        quot_r <= (st_r[ldc_pkg::DIV_STEPS].quo > 32'h8000_0000) ? ldc_pkg::Q_MIN :
                  $signed(~st_r[ldc_pkg::DIV_STEPS].quo + 32'd1);
      else
        quot_r <= st_r[ldc_pkg::DIV_STEPS].quo[31] ? ldc_pkg::Q_MAX :
                  $signed(st_r[ldc_pkg::DIV_STEPS].quo);
    end
  end

  assign quot = quot_r;

endmodule

/* rtl/ldc_lane.sv */
// ldc_lane: one direction's equilibrium and BGK relaxation, eight register stages.
// Depends on ldc_pkg.
`timescale 1ns / 1ps
module ldc_lane (
  input  logic              clk,
  input  logic              adv,
  input  logic signed [1:0] ex,
  input  logic signed [1:0] ey,
  input  ldc_pkg::q_t       weight,
  input  ldc_pkg::q_t       omega,
  input  ldc_pkg::q_t       keep,
  input  ldc_pkg::q_t       ux,
  input  ldc_pkg::q_t       uy,
  input  ldc_pkg::q_t       rho,
  input  ldc_pkg::q_t       f_in,
  input  ldc_pkg::q_t       uu,
  output ldc_pkg::q_t       post
);

  ldc_pkg::q_t  a_r, a1_r, a2_r, poly_r, rp_r, feq_r, post_r;
  ldc_pkg::qw_t t1_r, t2_r, p1_r, p2_r;
  logic signed [33:0] a3_r;
  ldc_pkg::q_t  rho_d [4];
  ldc_pkg::q_t  f_d   [6];

  function automatic logic signed [33:0] term(input logic signed [1:0] e,
                                              input ldc_pkg::q_t u);
    case (e)
      2'sd1:   return 34'(u);
      -2'sd1:  return -34'(u);
      default: return '0;
    endcase
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      // projection of velocity on this direction
      a_r    <= ldc_pkg::sat32(40'(term(ex, ux) + term(ey, uy)));
      // square
      a2_r   <= ldc_pkg::sat32(40'(ldc_pkg::mulq(a_r, a_r)));
      a1_r   <= a_r;
      // scaled terms
      t1_r   <= ldc_pkg::mulq(ldc_pkg::K_4P5, a2_r);
      t2_r   <= ldc_pkg::mulq(ldc_pkg::K_1P5, uu);
      a3_r   <= 34'(a1_r) * 34'sd3;
      // polynomial
      poly_r <= ldc_pkg::sat32(40'(ldc_pkg::Q_ONE) + 40'(a3_r) + 40'(t1_r) - 40'(t2_r));
      // equilibrium
      rp_r   <= ldc_pkg::sat32(40'(ldc_pkg::mulq(rho_d[3], poly_r)));
      feq_r  <= ldc_pkg::sat32(40'(ldc_pkg::mulq(weight, rp_r)));
      // relaxation
      p1_r   <= ldc_pkg::mulq(keep, f_d[5]);
      p2_r   <= ldc_pkg::mulq(omega, feq_r);
      post_r <= ldc_pkg::sat32(40'(p1_r) + 40'(p2_r));
      // side delays
      rho_d[0] <= rho;
      for (int i = 1; i < 4; i++) rho_d[i] <= rho_d[i-1];
      f_d[0] <= f_in;
      for (int i = 1; i < 6; i++) f_d[i] <= f_d[i-1];
    end
  end

  assign post = post_r;

endmodule

/* rtl/ldc_merge.sv */
// ldc_merge: combines lane outputs with the cell side data, output register and skid.
// Depends on ldc_pkg and ldc_out_if.
`timescale 1ns / 1ps
module ldc_merge (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  ldc_pkg::cell_t      side,
  input  ldc_pkg::flow_t      flow,
  input  ldc_pkg::dist_vec_t  post,
  output logic                adv,
  ldc_out_if.source           out_ch
);

  ldc_pkg::result_t res, out_r, skid_r;
  logic             out_valid_r, skid_valid_r;
  logic             out_free;

  // obstacle cells pass their distributions through
  always_comb begin
    if (side.kind == ldc_pkg::KIND_OBSTACLE) begin
      res.post    = side.dists;
      res.density = '0;
      res.vel_x   = '0;
      res.vel_y   = '0;
    end else begin
      res.post    = post;
      res.density = flow.rho;
      res.vel_x   = flow.ux;
      res.vel_y   = flow.uy;
    end
  end

  assign adv      = !skid_valid_r;
  assign out_free = !out_valid_r || out_ch.ready;

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_ch.ready) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (in_valid) begin
      if (out_free) begin
        out_r       <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.post_0  = out_r.post[0];
  assign out_ch.post_1  = out_r.post[1];
  assign out_ch.post_2  = out_r.post[2];
  assign out_ch.post_3  = out_r.post[3];
  assign out_ch.post_4  = out_r.post[4];
  assign out_ch.post_5  = out_r.post[5];
  assign out_ch.post_6  = out_r.post[6];
  assign out_ch.post_7  = out_r.post[7];
  assign out_ch.post_8  = out_r.post[8];
  assign out_ch.density = out_r.density;
  assign out_ch.vel_x   = out_r.vel_x;
  assign out_ch.vel_y   = out_r.vel_y;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r) else $error("skid holds a transaction with output empty");
  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_ch.ready) |=> (skid_valid_r && $stable(skid_r)))
    else $error("skid entry lost while output stalled");
  a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !skid_valid_r && out_valid_r && !out_ch.ready) |=> skid_valid_r)
    else $error("stalled transaction not captured in skid");

endmodule

/* rtl/lattice_boltzmann_d2q9_collide.sv */
// lattice_boltzmann_d2q9_collide: top level of the D2Q9 BGK collision kernel.
// Depends on ldc_pkg, ldc_if, ldc_moments, ldc_div, ldc_lane, ldc_merge.
`timescale 1ns / 1ps
//
//  port      dir  transaction
//  in_ch     in   nine streamed distributions and cell kind of one cell
//  out_ch    out  nine relaxed distributions, density, vel_x, vel_y
//  cfg_*     in   register write: index 0 relax_rate, 1 lid_velocity
//
//  One cell enters per cycle while in_ch.ready is high; each cell passes
//  through the moments register, the 18-stage divider (setup, 16 stages of
//  two quotient bits, sign), the velocity stage, the eight-stage lane
//  pipeline and the output register. Reset is synchronous: it clears the
//  valid bits and loads the register defaults. A stalled output fills one
//  skid entry, then the whole pipeline holds and in_ch.ready drops.
module lattice_boltzmann_d2q9_collide (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [ldc_pkg::CFG_W-1:0]  cfg_data,
  ldc_in_if.sink                     in_ch,
  ldc_out_if.source                  out_ch
);

  logic [ldc_pkg::RELAX_W-1:0] relax_rate_r;
  logic [ldc_pkg::LID_W-1:0]   lid_velocity_r;
  logic                        adv;
  logic                        vld_r [ldc_pkg::DEPTH];
  ldc_pkg::cell_t              cell_r [ldc_pkg::DEPTH];
  ldc_pkg::q_t                 rho_d [ldc_pkg::DIV_LAT];
  ldc_pkg::flow_t              flow_d [ldc_pkg::LANE_LAT];
  ldc_pkg::cell_t              cell_in;
  ldc_pkg::q_t                 rho, mom_x, mom_y, qx, qy;
  ldc_pkg::q_t                 vel_ux_r, vel_uy_r, vel_rho_r;
  ldc_pkg::qw_t                uxx_r, uyy_r;
  ldc_pkg::q_t                 uu_r, omega, keep;
  ldc_pkg::dist_vec_t          post;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      relax_rate_r   <= ldc_pkg::RELAX_RESET;
      lid_velocity_r <= ldc_pkg::LID_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ldc_pkg::REG_RELAX_RATE:   relax_rate_r   <= cfg_data[ldc_pkg::RELAX_W-1:0];
        ldc_pkg::REG_LID_VELOCITY: lid_velocity_r <= cfg_data[ldc_pkg::LID_W-1:0];
        default: ;
      endcase
    end
  end

  assign omega = $signed({2'b00, relax_rate_r});
  assign keep  = ldc_pkg::Q_ONE - omega;

  assign in_ch.ready = adv;

  always_comb begin
    cell_in.dists[0] = in_ch.dist_0;
    cell_in.dists[1] = in_ch.dist_1;
    cell_in.dists[2] = in_ch.dist_2;
    cell_in.dists[3] = in_ch.dist_3;
    cell_in.dists[4] = in_ch.dist_4;
    cell_in.dists[5] = in_ch.dist_5;
    cell_in.dists[6] = in_ch.dist_6;
    cell_in.dists[7] = in_ch.dist_7;
    cell_in.dists[8] = in_ch.dist_8;
    cell_in.kind     = in_ch.cell_kind;
  end

  // valid and cell side pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ldc_pkg::DEPTH; i++) vld_r[i] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_ch.valid;
      for (int i = 1; i < ldc_pkg::DEPTH; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cell_r[0] <= cell_in;
      for (int i = 1; i < ldc_pkg::DEPTH; i++) cell_r[i] <= cell_r[i-1];
    end
  end

  ldc_moments u_moments (
    .clk(clk), .adv(adv), .dists(cell_in.dists), .rho(rho), .mom_x(mom_x), .mom_y(mom_y)
  );

  ldc_div u_div_x (.clk(clk), .adv(adv), .num(mom_x), .den(rho), .quot(qx));
  ldc_div u_div_y (.clk(clk), .adv(adv), .num(mom_y), .den(rho), .quot(qy));

  // velocity stage: lid override, then |u|^2
  always_ff @(posedge clk) begin
    if (adv) begin
      rho_d[0] <= rho;
      for (int i = 1; i < ldc_pkg::DIV_LAT; i++) rho_d[i] <= rho_d[i-1];
      vel_rho_r <= rho_d[ldc_pkg::DIV_LAT-1];
      vel_uy_r  <= qy;
      if (cell_r[ldc_pkg::VEL_IDX-1].kind == ldc_pkg::KIND_LID)
        vel_ux_r <= 32'(lid_velocity_r) |
                    {{(ldc_pkg::DW-ldc_pkg::LID_W){lid_velocity_r[ldc_pkg::LID_W-1]}},
                     {ldc_pkg::LID_W{1'b0}}};
      else
        vel_ux_r <= qx;
      uxx_r <= ldc_pkg::mulq(vel_ux_r, vel_ux_r);
      uyy_r <= ldc_pkg::mulq(vel_uy_r, vel_uy_r);
      uu_r  <= ldc_pkg::sat32(40'(uxx_r) + 40'(uyy_r));
      flow_d[0] <= '{rho: vel_rho_r, ux: vel_ux_r, uy: vel_uy_r};
      for (int i = 1; i < ldc_pkg::LANE_LAT; i++) flow_d[i] <= flow_d[i-1];
    end
  end

  // one lane per direction
  for (genvar d = 0; d < ldc_pkg::NDIR; d++) begin : g_lane
    ldc_pkg::q_t lane_post;
    ldc_lane u_lane (
      .clk(clk), .adv(adv),
      .ex(ldc_pkg::dir_x(d)), .ey(ldc_pkg::dir_y(d)), .weight(ldc_pkg::dir_weight(d)),
      .omega(omega), .keep(keep),
      .ux(vel_ux_r), .uy(vel_uy_r), .rho(vel_rho_r),
      .f_in(cell_r[ldc_pkg::VEL_IDX].dists[d]),
      .uu(uu_r), .post(lane_post)
    );
    assign post[d] = lane_post;
  end

  ldc_merge u_merge (
    .clk(clk), .rst_n(rst_n),
    .in_valid(vld_r[ldc_pkg::DEPTH-1]),
    .side(cell_r[ldc_pkg::DEPTH-1]),
    .flow(flow_d[ldc_pkg::LANE_LAT-1]),
    .post(post),
    .adv(adv),
    .out_ch(out_ch)
  );

endmodule

/* test/lattice_boltzmann_d2q9_collide_tb.sv */
// Testbench for the D2Q9 BGK collision kernel: drives cells over the valid-ready
// channel and checks every result against an in-bench fixed-point predictor.
// Depends on ldc_pkg, ldc_if and the lattice_boltzmann_d2q9_collide top level.
`timescale 1ns / 1ps
module lattice_boltzmann_d2q9_collide_tb;

  localparam int N_RANDOM = 800;
  localparam int LATENCY  = 28;

  typedef struct {
    logic signed [31:0] d [9];
    logic [1:0]         kind;
  } cell_item_t;

  typedef struct {
    logic signed [31:0] p [9];
    logic signed [31:0] rho;
    logic signed [31:0] ux;
    logic signed [31:0] uy;
  } coll_res_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [ldc_pkg::CFG_W-1:0] cfg_data;

  ldc_in_if  in_ch();
  ldc_out_if out_ch();

  lattice_boltzmann_d2q9_collide uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
  );

  // predictor copy of the registers
  logic [29:0] omega_q;
  logic [28:0] lid_q;

  cell_item_t cell_queue[$];
  coll_res_t  expected_results[$];
  int errors = 0;
  int cells_sent = 0;
  int results_seen = 0;
  bit idle_enable;
  bit hold_out;

  // clock
  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // floor(x*y / 2^28); arithmetic shift floors
  function automatic longint qmul(longint x, longint y);
    longint p;
    p = x * y;
    return p >>> 28;
  endfunction

  function automatic int dir_xi(int l);
    case (l)
      1, 5, 7: return 1;
      2, 6, 8: return -1;
      default: return 0;
    endcase
  endfunction

  function automatic int dir_yi(int l);
    case (l)
      3, 5, 6: return 1;
      4, 7, 8: return -1;
      default: return 0;
    endcase
  endfunction

  function automatic coll_res_t collide(cell_item_t c);
    coll_res_t r;
    longint f [9];
    longint rho, mx, my, ux, uy, uu, om, keep, a, a2, poly, feq, w;
    int ex, ey;
    rho = 0; mx = 0; my = 0; ux = 0; uy = 0;
    for (int l = 0; l < 9; l++) f[l] = longint'(c.d[l]);
    if (c.kind == ldc_pkg::KIND_OBSTACLE) begin
      for (int l = 0; l < 9; l++) r.p[l] = c.d[l];
      r.rho = '0; r.ux = '0; r.uy = '0;
      return r;
    end
    for (int l = 0; l < 9; l++) begin
      rho += f[l];
      mx += dir_xi(l) * f[l];
      my += dir_yi(l) * f[l];
    end
    rho = clip32(rho); mx = clip32(mx); my = clip32(my);
    if (rho > 0) begin
      ux = clip32((mx * 64'sd268435456) / rho);
      uy = clip32((my * 64'sd268435456) / rho);
    end
    if (c.kind == ldc_pkg::KIND_LID) ux = longint'($signed(lid_q));
    uu = clip32(qmul(ux, ux) + qmul(uy, uy));
    om = longint'(omega_q);
    keep = 64'sd268435456 - om;
    for (int l = 0; l < 9; l++) begin
      ex = dir_xi(l); ey = dir_yi(l);
      w = (l == 0) ? 64'sd119304647 : (l < 5) ? 64'sd29826162 : 64'sd7456540;
      a = clip32(ex * ux + ey * uy);
      a2 = clip32(qmul(a, a));
      poly = clip32(64'sd268435456 + 3 * a + qmul(64'sd1207959552, a2)
                    - qmul(64'sd402653184, uu));
      feq = clip32(qmul(w, clip32(qmul(rho, poly))));
      r.p[l] = 32'(clip32(qmul(keep, f[l]) + qmul(om, feq)));
    end
    r.rho = 32'(rho); r.ux = 32'(ux); r.uy = 32'(uy);
    return r;
  endfunction

  // driver: presents queued cells, random idle bursts
  int gap_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        void'(cell_queue.pop_front());
        cells_sent++;
      end
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (!(in_ch.valid && !in_ch.ready) && idle_enable &&
                   $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(0, 7);
        in_ch.valid <= 1'b0;
      end else if (in_ch.valid && !in_ch.ready) begin
        // hold current transaction
      end else if (cell_queue.size() > 0) begin
        in_ch.valid <= 1'b1;
        {in_ch.dist_0, in_ch.dist_1, in_ch.dist_2} <=
          {cell_queue[0].d[0], cell_queue[0].d[1], cell_queue[0].d[2]};
        {in_ch.dist_3, in_ch.dist_4, in_ch.dist_5} <=
          {cell_queue[0].d[3], cell_queue[0].d[4], cell_queue[0].d[5]};
        {in_ch.dist_6, in_ch.dist_7, in_ch.dist_8} <=
          {cell_queue[0].d[6], cell_queue[0].d[7], cell_queue[0].d[8]};
        in_ch.cell_kind <= cell_queue[0].kind;
        expected_results.push_back(collide(cell_queue[0]));
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor: checks each result transaction, random backpressure
  int stall_left;
  always @(posedge clk) begin
    coll_res_t e;
    logic signed [31:0] got [12];
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.post_0, out_ch.post_1, out_ch.post_2, out_ch.post_3,
                out_ch.post_4, out_ch.post_5, out_ch.post_6, out_ch.post_7,
                out_ch.post_8, out_ch.density, out_ch.vel_x, out_ch.vel_y};
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: result with no expectation waiting, density %0d", $time,
                   got[9]);
          errors++;
        end else begin
          e = expected_results.pop_front();
          for (int k = 0; k < 9; k++)
            if (got[k] !== e.p[k]) begin
              $display("%0t: post_%0d expected %0d actual %0d", $time, k, e.p[k], got[k]);
              errors++;
            end
          if (got[9] !== e.rho) begin
            $display("%0t: density expected %0d actual %0d", $time, e.rho, got[9]);
            errors++;
          end
          if (got[10] !== e.ux) begin
            $display("%0t: vel_x expected %0d actual %0d", $time, e.ux, got[10]);
            errors++;
          end
          if (got[11] !== e.uy) begin
            $display("%0t: vel_y expected %0d actual %0d", $time, e.uy, got[11]);
            errors++;
          end
        end
      end
      if (hold_out) begin
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 7);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic logic signed [31:0] rand_dist();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'sh7fff_ffff;
      2: return 32'sh8000_0000;
      default: return $signed($urandom_range(0, 60000000)) - 32'sd10000000;
    endcase
  endfunction

  task automatic add_cell(logic [1:0] kind, logic signed [31:0] v);
    cell_item_t c;
    for (int l = 0; l < 9; l++) c.d[l] = v;
    c.kind = kind;
    cell_queue.push_back(c);
  endtask

  task automatic add_random(int count);
    cell_item_t c;
    for (int n = 0; n < count; n++) begin
      for (int l = 0; l < 9; l++) c.d[l] = rand_dist();
      c.kind = 2'($urandom_range(0, 3));
      cell_queue.push_back(c);
    end
  endtask

  // wait for the channel to drain, then a latency margin
  task automatic drain();
    wait (cell_queue.size() == 0 && !in_ch.valid && expected_results.size() == 0);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [ldc_pkg::CFG_W-1:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ldc_pkg::REG_RELAX_RATE) omega_q = val[29:0];
    else lid_q = val[28:0];
  endtask

  // stimulus sequence
  initial begin
    cell_item_t c;
    idle_enable = 1'b1; hold_out = 1'b0;
    cfg_we = 1'b0; cfg_index = 1'b0; cfg_data = '0;
    omega_q = ldc_pkg::RELAX_RESET; lid_q = ldc_pkg::LID_RESET;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset defaults, kinds, extremes, zero and negative density
    add_cell(ldc_pkg::KIND_FLUID, 32'sd29826162);
    add_cell(ldc_pkg::KIND_LID, 32'sd29826162);
    add_cell(ldc_pkg::KIND_OBSTACLE, 32'sh8000_0000);
    add_cell(ldc_pkg::KIND_SPARE, 32'sd29826162);
    add_cell(ldc_pkg::KIND_FLUID, 32'sd0);
    add_cell(ldc_pkg::KIND_FLUID, -32'sd1000);
    add_cell(ldc_pkg::KIND_LID, -32'sd5000);
    add_cell(ldc_pkg::KIND_FLUID, 32'sh7fff_ffff);
    add_cell(ldc_pkg::KIND_FLUID, 32'sh8000_0000);
    add_cell(ldc_pkg::KIND_OBSTACLE, 32'sh7fff_ffff);
    for (int k = 0; k < 9; k++) begin
      for (int l = 0; l < 9; l++) c.d[l] = (l == k) ? 32'sh7fff_ffff : 32'sd100;
      c.kind = ldc_pkg::KIND_FLUID;
      cell_queue.push_back(c);
    end
    for (int l = 0; l < 9; l++) c.d[l] = (l % 2) ? 32'sh8000_0000 : 32'sh7fff_ffff;
    c.kind = ldc_pkg::KIND_FLUID;
    cell_queue.push_back(c);
    drain();

    // relax rate extremes and lid velocity extremes
    write_reg(ldc_pkg::REG_RELAX_RATE, 30'd0);
    write_reg(ldc_pkg::REG_LID_VELOCITY, 30'(29'h1000_0000));
    add_random(150);
    drain();
    write_reg(ldc_pkg::REG_RELAX_RATE, 30'd536870912);
    write_reg(ldc_pkg::REG_LID_VELOCITY, 30'd134217728);
    add_random(150);
    drain();
    write_reg(ldc_pkg::REG_RELAX_RATE, 30'h3fff_ffff);
    write_reg(ldc_pkg::REG_LID_VELOCITY, 30'h1fff_ffff);
    add_random(100);
    drain();

    // long receiver hold-off while the sender keeps offering
    write_reg(ldc_pkg::REG_RELAX_RATE, 30'($urandom_range(0, 536870912)));
    write_reg(ldc_pkg::REG_LID_VELOCITY,
              30'($signed($urandom_range(0, 268435456)) - 134217728));
    hold_out = 1'b1;
    add_random(150);
    repeat (120) @(posedge clk);
    hold_out = 1'b0;
    drain();

    // last part without idling
    idle_enable = 1'b0;
    write_reg(ldc_pkg::REG_RELAX_RATE, 30'(ldc_pkg::RELAX_RESET));
    write_reg(ldc_pkg::REG_LID_VELOCITY, 30'(ldc_pkg::LID_RESET));
    add_random(250);
    drain();

    $display("Sent %0d cells over kinds, density signs and register extremes; %0d results",
             cells_sent, results_seen);
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // timeout
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

/* files.f */
rtl/ldc_pkg.sv
rtl/ldc_if.sv
rtl/ldc_moments.sv
rtl/ldc_div.sv
rtl/ldc_lane.sv
rtl/ldc_merge.sv
rtl/lattice_boltzmann_d2q9_collide.sv
test/lattice_boltzmann_d2q9_collide_tb.sv
